@@ sv/scmt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scmt_pkg
// Types, constants and helpers shared by the solution class merge table.
// ----------------------------------------------------------------------------
package scmt_pkg;

    localparam int MAX_CLASSES = 64;
    localparam int MAX_VARS    = 5;
    localparam int COORD_W     = 32;
    localparam int OBJ_W       = 32;
    localparam int HIT_W       = 16;
    localparam int IDX_W       = $clog2(MAX_CLASSES);
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
    localparam int VC_W        = 3;
    localparam int TOL_W       = 32;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VAR_COUNT       = CFG_IDX_W'(1);

    localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(16777);
    localparam logic [VC_W-1:0]    VC_RESET  = VC_W'(2);
    localparam logic [HIT_W-1:0]   HIT_MAX   = {HIT_W{1'b1}};
    localparam logic [COORD_W-1:0] KEY_BIAS  = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic [MAX_VARS-1:0][COORD_W-1:0] coord_vec_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_0;
        logic signed [COORD_W-1:0] coord_1;
        logic signed [COORD_W-1:0] coord_2;
        logic signed [COORD_W-1:0] coord_3;
        logic signed [COORD_W-1:0] coord_4;
        logic [OBJ_W-1:0]          objective;
        logic [HIT_W-1:0]          hit_count;
        logic                      batch_last;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] class_index;
        logic             is_new;
        logic             improved;
        logic [HIT_W-1:0] class_total;
        logic             table_full;
        logic [CNT_W-1:0] classes_in_use;
        logic             batch_end;
    } out_item_t;

    typedef struct packed {
        coord_vec_t       coords;
        logic [OBJ_W-1:0] best;
        logic [HIT_W-1:0] hits;
    } class_row_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic decided;
        logic out_free;
    } dp_status_t;

    function automatic logic [VC_W-1:0] active_vars(input logic [VC_W-1:0] vc);
        logic [VC_W-1:0] n;
        n = vc;
        if (n == VC_W'(0)) begin
            n = VC_W'(1);
        end else if (n > VC_W'(MAX_VARS)) begin
            n = VC_W'(MAX_VARS);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ sv/scmt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scmt_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module scmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/scmt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scmt_datapath
// Candidate registers, class store, lane compare, update and result register.
// ----------------------------------------------------------------------------
module scmt_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire scmt_pkg::ctrl_cmd_t             cmd,
    output scmt_pkg::dp_status_t                 status,
    input  wire scmt_pkg::in_item_t              s_data,
    output scmt_pkg::out_item_t                  m_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    input  wire logic                            cfg_valid,
    input  wire logic [scmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scmt_pkg::CFG_DATA_W-1:0] cfg_data
);

    import scmt_pkg::*;

    logic [TOL_W-1:0]  tol_reg;
    logic [VC_W-1:0]   vc_reg;
    logic [VC_W-1:0]   nv;

    coord_vec_t        cand_reg;
    logic [OBJ_W-1:0]  obj_reg;
    logic [HIT_W-1:0]  hits_in_reg;
    logic              last_reg;

    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  issue_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    class_row_t        rd_row;

    logic              wr_en_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    class_row_t        wr_row_reg;
    out_item_t         res_reg;
    out_item_t         commit_res;

    logic              m_valid_reg;
    out_item_t         m_data_reg;

    coord_vec_t        in_coords;
    logic [MAX_VARS-1:0] lane_ok;
    logic              match, hit, exhausted, full, issue, improve;
    logic [HIT_W:0]    sum_wide;
    logic [HIT_W-1:0]  sum_sat;

    assign nv = active_vars(vc_reg);

    assign in_coords[0] = s_data.coord_0;
    assign in_coords[1] = s_data.coord_1;
    assign in_coords[2] = s_data.coord_2;
    assign in_coords[3] = s_data.coord_3;
    assign in_coords[4] = s_data.coord_4;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
            vc_reg  <= VC_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MATCH_TOLERANCE) begin
                tol_reg <= cfg_data[TOL_W-1:0];
            end else if (cfg_index == REG_VAR_COUNT) begin
                vc_reg <= cfg_data[VC_W-1:0];
            end
        end
    end

    // candidate capture, inactive lanes stored as zero
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int k = 0; k < MAX_VARS; k++) begin
                cand_reg[k] <= (VC_W'(k) < nv) ? in_coords[k] : '0;
            end
            obj_reg     <= s_data.objective;
            hits_in_reg <= s_data.hit_count;
            last_reg    <= s_data.batch_last;
        end
    end

    // class store
    assign issue = cmd.scan && (issue_reg < used_reg);

    scmt_ram #(
        .WIDTH ($bits(class_row_t)),
        .DEPTH (MAX_CLASSES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.commit && wr_en_reg),
        .waddr (wr_idx_reg),
        .wdata (wr_row_reg),
        .re    (issue),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (rd_row)
    );

    // per-lane distance check on order-preserving keys
    for (genvar k = 0; k < MAX_VARS; k++) begin : g_lane
        logic [COORD_W-1:0] ka, kb, diff;
        assign ka      = cand_reg[k] ^ KEY_BIAS;
        assign kb      = rd_row.coords[k] ^ KEY_BIAS;
        assign diff    = (ka >= kb) ? (ka - kb) : (kb - ka);
        assign lane_ok[k] = (VC_W'(k) >= nv) || (diff <= tol_reg);
    end

    assign match     = &lane_ok;
    assign hit       = cmd.scan && rd_valid_reg && match;
    assign exhausted = cmd.scan && !rd_valid_reg && (issue_reg == used_reg);
    assign full      = used_reg == CNT_W'(MAX_CLASSES);

    assign sum_wide = {1'b0, rd_row.hits} + {1'b0, hits_in_reg};
    assign sum_sat  = sum_wide[HIT_W] ? HIT_MAX : sum_wide[HIT_W-1:0];
    assign improve  = obj_reg < rd_row.best;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
            if (issue) begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_idx_reg <= issue_reg[IDX_W-1:0];
        end
    end

    // decision
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_en_reg <= 1'b0;
        end else if (hit) begin
            wr_en_reg <= 1'b1;
        end else if (exhausted) begin
            wr_en_reg <= !full;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit) begin
            wr_idx_reg        <= rd_idx_reg;
            wr_row_reg.coords <= improve ? cand_reg : rd_row.coords;
            wr_row_reg.best   <= improve ? obj_reg : rd_row.best;
            wr_row_reg.hits   <= sum_sat;
            res_reg.class_index    <= rd_idx_reg;
            res_reg.is_new         <= 1'b0;
            res_reg.improved       <= improve;
            res_reg.class_total    <= sum_sat;
            res_reg.table_full     <= 1'b0;
            res_reg.classes_in_use <= '0;
            res_reg.batch_end      <= last_reg;
        end else if (exhausted) begin
            wr_idx_reg        <= used_reg[IDX_W-1:0];
            wr_row_reg.coords <= cand_reg;
            wr_row_reg.best   <= obj_reg;
            wr_row_reg.hits   <= hits_in_reg;
            res_reg.class_index    <= full ? '0 : used_reg[IDX_W-1:0];
            res_reg.is_new         <= !full;
            res_reg.improved       <= 1'b0;
            res_reg.class_total    <= full ? '0 : hits_in_reg;
            res_reg.table_full     <= full;
            res_reg.classes_in_use <= '0;
            res_reg.batch_end      <= last_reg;
        end
    end

    // commit and result register
    assign used_next = used_reg + CNT_W'(res_reg.is_new);

    always_comb begin
        commit_res                = res_reg;
        commit_res.classes_in_use = used_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            used_reg    <= used_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= commit_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.decided  = hit || exhausted;
    assign status.out_free = !m_valid_reg || m_ready;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(MAX_CLASSES))
        else $error("class count beyond table size");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_reg <= used_reg)
        else $error("scan ran past the used classes");

    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("commit without a result");

    a_new_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && res_reg.is_new) |=> used_reg == $past(used_next))
        else $error("new class not counted");

endmodule
`default_nettype wire

@@ sv/scmt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scmt_ctrl
// Sequencer: accept a candidate, scan the class store, commit the update.
// ----------------------------------------------------------------------------
module scmt_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output scmt_pkg::ctrl_cmd_t       cmd,
    input  wire scmt_pkg::dp_status_t status
);

    import scmt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg, state_next;

    assign s_ready    = state_reg == ST_IDLE;
    assign cmd.load   = s_valid && s_ready;
    assign cmd.scan   = state_reg == ST_SCAN;
    assign cmd.commit = (state_reg == ST_COMMIT) && status.out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.decided) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_scan_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.scan)
        else $error("transaction taken but no scan");

    a_commit_after_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan && status.decided) |=> (state_reg == ST_COMMIT))
        else $error("decision not followed by commit");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan || state_reg == ST_COMMIT) |-> !s_ready)
        else $error("ready while busy");

endmodule
`default_nettype wire

@@ sv/solution_class_merge_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// solution_class_merge_table
// Merges candidate solutions into a table of up to 64 solution classes.
// ----------------------------------------------------------------------------
// Each candidate is compared, in class order, with the stored classes up to
// the first match, one class per cycle out of the single read port of the
// class store, with up to five coordinates checked in parallel. The first
// class within tolerance takes the candidate's hits and, on a lower
// objective, its coordinates and objective; with no match the candidate
// opens a new class, or is dropped and flagged when the table is full. The
// next candidate is taken while the previous result still waits on the
// output.
// Configuration: index 0 is the match tolerance, index 1 the variable count.
// ----------------------------------------------------------------------------
module solution_class_merge_table (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire scmt_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output scmt_pkg::out_item_t                  m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [scmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scmt_pkg::CFG_DATA_W-1:0] cfg_data
);

    import scmt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    scmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    scmt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the solution class merge table.
// ----------------------------------------------------------------------------
// Candidates go in over a valid/ready channel. A behavioural copy of the class
// table works out the result of each accepted candidate, and each result that
// comes out is compared field by field, in order, with those predictions.
// The named tests run in turn: directed edge cases, every var_count code,
// both tolerance extremes, a long output hold-off that backs up the input
// side, and four idle and stall mixes with near-match heavy traffic that
// fills the table. Register writes happen only once every result has arrived.
// ----------------------------------------------------------------------------
module tb_top;
    import scmt_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic aclk;
    logic aresetn = 1'b0;

    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // class table as the bench sees it
    logic [COORD_W-1:0] tbl_coord [MAX_CLASSES][MAX_VARS];
    logic [OBJ_W-1:0]   tbl_best [MAX_CLASSES];
    logic [HIT_W-1:0]   tbl_hits [MAX_CLASSES];
    int unsigned        tbl_used = 0;
    logic [TOL_W-1:0]   cur_tol = TOL_RESET;
    logic [VC_W-1:0]    cur_vc = VC_RESET;

    out_item_t merge_expect_q [$];
    out_item_t want_res;

    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_off = 1'b0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int n_merged = 0;
    int n_new = 0;
    int n_matched = 0;
    int n_improved = 0;
    int n_dropped = 0;

    solution_class_merge_table uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned lanes_in_use();
        int unsigned n;
        n = cur_vc;
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_VARS) begin
            n = MAX_VARS;
        end
        return n;
    endfunction

    // updates the bench table and returns the result the block should give
    function automatic out_item_t merge_candidate(input in_item_t c);
        out_item_t r;
        logic [COORD_W-1:0] cv [MAX_VARS];
        int unsigned n, i, k, at;
        logic same, found;
        logic signed [COORD_W:0] d;
        logic [COORD_W:0] mag;
        logic [HIT_W:0] sum;
        cv[0] = c.coord_0;
        cv[1] = c.coord_1;
        cv[2] = c.coord_2;
        cv[3] = c.coord_3;
        cv[4] = c.coord_4;
        n = lanes_in_use();
        found = 1'b0;
        at = 0;
        for (i = 0; i < tbl_used && !found; i++) begin
            same = 1'b1;
            for (k = 0; k < n; k++) begin
                d = $signed({cv[k][COORD_W-1], cv[k]}) -
                    $signed({tbl_coord[i][k][COORD_W-1], tbl_coord[i][k]});
                mag = (d < 0) ? -d : d;
                if (mag > {1'b0, cur_tol}) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                found = 1'b1;
                at = i;
            end
        end
        r = '0;
        r.batch_end = c.batch_last;
        n_merged++;
        if (found) begin
            sum = {1'b0, tbl_hits[at]} + {1'b0, c.hit_count};
            tbl_hits[at] = sum[HIT_W] ? HIT_MAX : sum[HIT_W-1:0];
            if (c.objective < tbl_best[at]) begin
                tbl_best[at] = c.objective;
                for (k = 0; k < MAX_VARS; k++) begin
                    tbl_coord[at][k] = (k < n) ? cv[k] : '0;
                end
                r.improved = 1'b1;
                n_improved++;
            end
            r.class_index = IDX_W'(at);
            r.class_total = tbl_hits[at];
            n_matched++;
        end else if (tbl_used < MAX_CLASSES) begin
            at = tbl_used;
            for (k = 0; k < MAX_VARS; k++) begin
                tbl_coord[at][k] = (k < n) ? cv[k] : '0;
            end
            tbl_best[at] = c.objective;
            tbl_hits[at] = c.hit_count;
            tbl_used++;
            r.class_index = IDX_W'(at);
            r.is_new = 1'b1;
            r.class_total = c.hit_count;
            n_new++;
        end else begin
            r.table_full = 1'b1;
            n_dropped++;
        end
        r.classes_in_use = CNT_W'(tbl_used);
        return r;
    endfunction

    function automatic in_item_t mk_item(input logic [COORD_W-1:0] c0, c1, c2, c3, c4,
                                         input logic [OBJ_W-1:0] obj,
                                         input logic [HIT_W-1:0] hits,
                                         input logic last);
        in_item_t c;
        c.coord_0 = c0;
        c.coord_1 = c1;
        c.coord_2 = c2;
        c.coord_3 = c3;
        c.coord_4 = c4;
        c.objective = obj;
        c.hit_count = hits;
        c.batch_last = last;
        return c;
    endfunction

    // mostly near matches of a stored class, some fresh points, some just outside
    function automatic in_item_t draw_candidate();
        in_item_t c;
        logic [COORD_W-1:0] v [MAX_VARS];
        logic [OBJ_W-1:0] obj;
        logic [HIT_W-1:0] hits;
        int unsigned n, r, pick, k, miss, sel;
        longint span, off, val;
        n = lanes_in_use();
        r = $urandom_range(0, 99);
        pick = (tbl_used == 0) ? 0 : $urandom_range(0, tbl_used - 1);
        miss = (r >= 90) ? $urandom_range(0, n - 1) : MAX_VARS;
        span = cur_tol;
        for (k = 0; k < MAX_VARS; k++) begin
            if (r < 15 || tbl_used == 0 || k >= n) begin
                v[k] = $urandom;
            end else begin
                sel = $urandom_range(0, 3);
                if (sel == 0) begin
                    off = 0;
                end else if (sel == 1) begin
                    off = span;
                end else begin
                    off = $urandom_range(0, (span > 1048576) ? 1048576 : span);
                end
                if (k == miss) begin
                    off = span + 1 + $urandom_range(0, 15);
                end
                if ($urandom_range(0, 1) == 1) begin
                    off = -off;
                end
                val = longint'($signed(tbl_coord[pick][k])) + off;
                if (val > 64'sd2147483647) begin
                    val = 64'sd2147483647;
                end else if (val < -64'sd2147483648) begin
                    val = -64'sd2147483648;
                end
                v[k] = val[COORD_W-1:0];
            end
        end
        if (r >= 15 && tbl_used != 0 && $urandom_range(0, 9) == 0) begin
            obj = tbl_best[pick];
        end else begin
            obj = $urandom;
        end
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            hits = HIT_W'($urandom_range(1, 300));
        end else if (sel < 95) begin
            hits = HIT_W'($urandom_range(1, 65535));
        end else if (sel < 98) begin
            hits = HIT_MAX;
        end else begin
            hits = '0;
        end
        c = mk_item(v[0], v[1], v[2], v[3], v[4], obj, hits, 1'($urandom_range(0, 1)));
        return c;
    endfunction

    task automatic send_candidate(input in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        merge_expect_q.push_back(merge_candidate(item));
    endtask

    // writes both registers once the block has drained
    task automatic configure(input logic [TOL_W-1:0] tol, input logic [VC_W-1:0] vc);
        logic [CFG_IDX_W-1:0] reg_at [2];
        logic [CFG_DATA_W-1:0] val [2];
        int i;
        s_valid <= 1'b0;
        while (merge_expect_q.size() != 0) @(posedge aclk);
        reg_at[0] = REG_MATCH_TOLERANCE;
        val[0] = CFG_DATA_W'(tol);
        reg_at[1] = REG_VAR_COUNT;
        val[1] = CFG_DATA_W'(vc);
        for (i = 0; i < 2; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_at[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cur_tol = tol;
        cur_vc = vc;
    endtask

    task automatic run_traffic(input int idle_pct, input int stall, input int count);
        int i;
        send_idle_pct = idle_pct;
        stall_pct <= stall;
        for (i = 0; i < count; i++) begin
            send_candidate(draw_candidate());
        end
    endtask

    // reset settings: coordinate extremes, zero and saturating hits, tolerance edge
    task automatic test_directed();
        send_candidate(mk_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'hFFFF_FFFF, 16'h0000, 1'b0));
        send_candidate(mk_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF, 1'b1));
        send_candidate(mk_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF, 1'b0));
        send_candidate(mk_item(32'h8000_4189, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                               32'h1234_5678, 32'hFFFF_FFFE, 16'd5, 1'b1));
        send_candidate(mk_item(32'h8000_8313, 32'h8000_4189, 32'h0, 32'h0, 32'h0,
                               32'h0000_1000, 16'd7, 1'b0));
        send_candidate(mk_item(32'hFFFF_FFFF, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555,
                               32'hFFFF_FFFF, 32'h3000_0000, 16'd1, 1'b1));
        send_candidate(mk_item(32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                               32'h4000_0000, 16'd2, 1'b0));
        send_candidate(mk_item(32'h0000_0001, 32'h0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h1,
                               32'h2000_0000, 16'd3, 1'b1));
        send_candidate(mk_item(32'h7FFF_BE76, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
                               32'h0000_0000, 16'd1, 1'b0));
        send_candidate(mk_item(32'h0000_418B, 32'h0, 32'h0, 32'h0, 32'h0,
                               32'h1000_0000, 16'd9, 1'b0));
        send_candidate(mk_item(32'h0000_0000, 32'hFFFF_BE77, 32'hFFFF_FFFF, 32'h0, 32'h0,
                               32'h2000_0000, 16'd4, 1'b1));
    endtask

    // codes 0, 7 and 6 clamp; then every legal count with fresh traffic
    task automatic test_var_count_range();
        int vc;
        configure(TOL_RESET, 3'd0);
        send_candidate(mk_item(32'h0000_0001, 32'h4000_0000, $urandom, $urandom, $urandom,
                               $urandom, 16'd4, 1'b0));
        send_candidate(mk_item(32'h8000_8313, 32'h1234_5678, $urandom, $urandom, $urandom,
                               $urandom, 16'd6, 1'b1));
        configure(TOL_RESET, 3'd7);
        send_candidate(mk_item(32'h8000_4189, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
                               32'hFFFF_FFFF, 16'd1, 1'b0));
        send_candidate(mk_item(32'h8000_4189, 32'h8000_0000, 32'h0, 32'h0, 32'h0000_418A,
                               32'h0000_0001, 16'd1, 1'b1));
        configure(TOL_RESET, 3'd6);
        send_candidate(mk_item(32'h8000_4189, 32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_BE77,
                               32'h0000_0001, 16'd2, 1'b0));
        for (vc = 1; vc <= MAX_VARS; vc++) begin
            configure(TOL_W'(vc) << 16, VC_W'(vc));
            run_traffic(0, 0, 8);
        end
    endtask

    task automatic test_tolerance_extremes();
        configure('0, 3'd3);
        run_traffic(0, 0, 8);
        configure('1, 3'd5);
        run_traffic(0, 0, 8);
    endtask

    task automatic test_idle_modes();
        configure(32'h0100_0000, 3'd3);
        run_traffic(0, 0, 280);
        configure(32'h0001_0000, 3'd5);
        run_traffic(60, 0, 280);
        configure(TOL_W'($urandom_range(0, 32'h00FF_FFFF)), 3'd1);
        run_traffic(0, 60, 280);
        configure(TOL_RESET, 3'd4);
        run_traffic(37, 37, 280);
    endtask

    // output held off while candidates keep coming, so the input side backs up
    task automatic test_receiver_hold_off();
        int i;
        configure(32'h0004_0000, 3'd2);
        send_idle_pct = 0;
        stall_pct <= 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
            for (i = 0; i < 12; i++) begin
                send_candidate(draw_candidate());
            end
        join
    endtask

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (merge_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: result with nothing pending: idx=%0d new=%0b imp=%0b",
                             $realtime, m_data.class_index, m_data.is_new, m_data.improved);
                end
            end else begin
                want_res = merge_expect_q.pop_front();
                if (m_data.class_index !== want_res.class_index ||
                    m_data.is_new !== want_res.is_new ||
                    m_data.improved !== want_res.improved ||
                    m_data.class_total !== want_res.class_total ||
                    m_data.table_full !== want_res.table_full ||
                    m_data.classes_in_use !== want_res.classes_in_use ||
                    m_data.batch_end !== want_res.batch_end) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: mismatch exp idx=%0d new=%0b imp=%0b tot=%0d full=%0b %s",
                                 $realtime, want_res.class_index, want_res.is_new,
                                 want_res.improved, want_res.class_total,
                                 want_res.table_full, "");
                        $display("    exp used=%0d end=%0b | got idx=%0d new=%0b imp=%0b",
                                 want_res.classes_in_use, want_res.batch_end,
                                 m_data.class_index, m_data.is_new, m_data.improved);
                        $display("    got tot=%0d full=%0b used=%0d end=%0b",
                                 m_data.class_total, m_data.table_full,
                                 m_data.classes_in_use, m_data.batch_end);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_var_count_range();
        test_tolerance_extremes();
        test_receiver_hold_off();
        test_idle_modes();
        s_valid <= 1'b0;
        while (merge_expect_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("%0d candidates: %0d new classes, %0d matches (%0d improved), %0d dropped",
                 n_merged, n_new, n_matched, n_improved, n_dropped);
        $display("var_count codes 0 to 7, tolerance 0 to max, four idle mixes, long hold-off");
        if (fail_count == 0 && merge_expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ solution_class_merge_table.f @@
sv/scmt_pkg.sv
sv/scmt_ram.sv
sv/scmt_datapath.sv
sv/scmt_ctrl.sv
sv/solution_class_merge_table.sv
tb/tb_top.sv
